FILE: hw/rtl/disjoint_set_union_engine_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the disjoint-set union engine
// Shared concurrent assertion forms, clocked on the rising edge, off in reset
// ----------------------------------------------------------------------------
`ifndef DISJOINT_SET_UNION_ENGINE_ASSERT_SVH
`define DISJOINT_SET_UNION_ENGINE_ASSERT_SVH

// property must hold at every edge outside reset
`define DSUE_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// condition must never be seen outside reset
`define DSUE_ASSERT_NEVER(label, clk, rst, cond, msg) \
  `DSUE_ASSERT(label, clk, rst, !(cond), msg)

`endif

FILE: hw/rtl/dsu_pkg.sv
// ----------------------------------------------------------------------------
// dsu_pkg
// Shared types and constants of the disjoint-set union engine
// ----------------------------------------------------------------------------
package dsu_pkg;

  // default table depth
  localparam int MAX_ELEMENTS = 1024;

  // fixed field widths
  localparam int OP_W    = 2;
  localparam int INDEX_W = 10;
  localparam int COUNT_W = 11;

  // operation codes
  localparam logic [OP_W-1:0] OP_UNITE = 2'd0;
  localparam logic [OP_W-1:0] OP_SAME  = 2'd1;
  localparam logic [OP_W-1:0] OP_FIND  = 2'd2;
  localparam logic [OP_W-1:0] OP_SIZE  = 2'd3;

  // status codes
  localparam logic STATUS_OK    = 1'b0;
  localparam logic STATUS_RANGE = 1'b1;

  // register map: paddr selects a 32-bit register at 4*i
  localparam int   CFG_ADDR_W   = 3;
  localparam logic REG_ELEMENTS = 1'b0;
  localparam logic [COUNT_W-1:0] ELEMENTS_RESET = 11'd1024;

  // request payload
  typedef struct packed {
    logic [OP_W-1:0]    operation;
    logic [INDEX_W-1:0] first_index;
    logic [INDEX_W-1:0] second_index;
  } req_t;

  // response payload
  typedef struct packed {
    logic               status;
    logic               answer_flag;
    logic [INDEX_W-1:0] root_index;
    logic [COUNT_W-1:0] group_size;
    logic [COUNT_W-1:0] num_groups;
  } rsp_t;

endpackage

FILE: hw/rtl/dsu_link_ram.sv
// ----------------------------------------------------------------------------
// dsu_link_ram
// Link table storage: one write port, one read port with registered data
// ----------------------------------------------------------------------------
module dsu_link_ram #(
  parameter int DEPTH  = dsu_pkg::MAX_ELEMENTS,
  parameter int ADDR_W = $clog2(DEPTH),
  parameter int DATA_W = $clog2(DEPTH + 1) + 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

FILE: hw/rtl/disjoint_set_union_engine.sv
// ----------------------------------------------------------------------------
// disjoint_set_union_engine
// Union-find table with union by size and full path compression
// ----------------------------------------------------------------------------
// Usage:
// A request transaction (req, req_valid, req_stall) carries an operation
// (unite, same-group test, find root, group size) and two element indices.
// Each request gives exactly one response transaction (rsp, rsp_valid,
// rsp_stall) with status, flag, root, group size and group count.
// The engine takes one request at a time; req_stall is high while it works.
// After acceptance each find issues a read, walks the links to the root
// and compresses the path; find/size run one find, unite/same two, a merge
// adds a merge and a link step, and a range error goes straight to the
// result. The walk uses the single read port; compression keeps it short.
// The response sits in an output register: a stalled response holds and
// a new request is still taken; the engine waits only if a second
// response is ready before the first is taken.
// After reset and after every write of elements_in_use a clearing pass
// over all MAX_ELEMENTS entries rebuilds the table, with req_stall high.
// elements_in_use lies at APB address 0; pready is always high.
// ----------------------------------------------------------------------------
module disjoint_set_union_engine #(
  parameter int MAX_ELEMENTS = dsu_pkg::MAX_ELEMENTS
) (
  input  logic                            clk,
  input  logic                            rst,
  // request channel
  input  dsu_pkg::req_t                   req,
  input  logic                            req_valid,
  output logic                            req_stall,
  // response channel
  output dsu_pkg::rsp_t                   rsp,
  output logic                            rsp_valid,
  input  logic                            rsp_stall,
  // configuration port
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [dsu_pkg::CFG_ADDR_W-1:0]  paddr,
  input  logic [31:0]                     pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready
);

  localparam int IDX_W   = $clog2(MAX_ELEMENTS);
  localparam int SIZE_W  = $clog2(MAX_ELEMENTS + 1);
  localparam int ENTRY_W = SIZE_W + 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_ELEMENTS - 1);

  typedef enum logic [7:0] {
    ST_CLEAR    = 8'b0000_0001,
    ST_IDLE     = 8'b0000_0010,
    ST_ISSUE    = 8'b0000_0100,
    ST_WALK     = 8'b0000_1000,
    ST_COMPRESS = 8'b0001_0000,
    ST_MERGE    = 8'b0010_0000,
    ST_LINK     = 8'b0100_0000,
    ST_RESULT   = 8'b1000_0000
  } state_t;

  state_t                       state;
  logic [IDX_W-1:0]             clr_cnt;
  logic [dsu_pkg::COUNT_W-1:0]  elements_in_use;
  logic [dsu_pkg::INDEX_W-1:0]  merge_count;
  logic [dsu_pkg::OP_W-1:0]     op;
  logic                         err;
  logic                         phase_b;
  logic                         flag;
  logic [IDX_W-1:0]             x;
  logic [IDX_W-1:0]             second;
  logic [IDX_W-1:0]             cur;
  logic [IDX_W-1:0]             root;
  logic [SIZE_W-1:0]            root_size;
  logic [IDX_W-1:0]             ra;
  logic [SIZE_W-1:0]            sa;

  // ram port
  logic                         we;
  logic [IDX_W-1:0]             waddr;
  logic [ENTRY_W-1:0]           wdata;
  logic [IDX_W-1:0]             raddr;
  logic [ENTRY_W-1:0]           rdata;

  logic                         rd_root;
  logic [SIZE_W-1:0]            rd_val;
  logic [IDX_W-1:0]             parent;
  logic                         cfg_we;
  logic                         accept;
  logic                         rsp_busy;
  logic                         uses_second;
  logic                         range_bad;
  logic                         comp_done;
  logic [dsu_pkg::COUNT_W-1:0]  n_active;
  logic [dsu_pkg::COUNT_W-1:0]  merges_ext;
  logic [dsu_pkg::COUNT_W-1:0]  groups;
  logic [IDX_W-1:0]             keep;
  logic [IDX_W-1:0]             drop;
  logic [SIZE_W-1:0]            merged_size;

  dsu_link_ram #(
    .DEPTH  (MAX_ELEMENTS),
    .ADDR_W (IDX_W),
    .DATA_W (ENTRY_W)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  // entry decode: top bit marks a root, low bits hold size or parent
  assign rd_root = rdata[ENTRY_W-1];
  assign rd_val  = rdata[SIZE_W-1:0];
  assign parent  = rd_val[IDX_W-1:0];

  // configuration access
  assign pready = 1'b1;
  assign cfg_we = psel & penable & pwrite & (paddr[2] == dsu_pkg::REG_ELEMENTS);
  assign prdata = (paddr[2] == dsu_pkg::REG_ELEMENTS) ? 32'(elements_in_use) : 32'd0;

  // active element count, saturated at the table depth
  assign n_active = (32'(elements_in_use) > 32'(MAX_ELEMENTS)) ?
                    dsu_pkg::COUNT_W'(MAX_ELEMENTS) : elements_in_use;
  assign merges_ext = {1'b0, merge_count};
  assign groups     = (n_active > merges_ext) ? (n_active - merges_ext) : '0;

  // handshakes
  assign req_stall = (state != ST_IDLE);
  assign accept    = req_valid & ~req_stall;
  assign rsp_busy  = rsp_valid & rsp_stall;

  // range check of the incoming transaction
  assign uses_second = (req.operation == dsu_pkg::OP_UNITE) ||
                       (req.operation == dsu_pkg::OP_SAME);
  assign range_bad   = ({1'b0, req.first_index} >= n_active) ||
                       (uses_second && ({1'b0, req.second_index} >= n_active));

  // compression ends at the root, found by index or by the root mark of the entry read
  assign comp_done = (cur == root) || rd_root;

  // union by size: on a tie the first root stays root
  assign keep        = (sa < root_size) ? root : ra;
  assign drop        = (sa < root_size) ? ra : root;
  assign merged_size = sa + root_size;

  // table port control
  always_comb begin
    we    = 1'b0;
    waddr = clr_cnt;
    wdata = {1'b1, SIZE_W'(1)};
    raddr = cur;
    case (state)
      ST_CLEAR: begin
        we = 1'b1;
      end
      ST_ISSUE: begin
        raddr = x;
      end
      ST_WALK: begin
        raddr = rd_root ? x : parent;
      end
      ST_COMPRESS: begin
        if (!comp_done) begin
          we    = 1'b1;
          waddr = cur;
          wdata = {1'b0, SIZE_W'(root)};
          raddr = parent;
        end
      end
      ST_MERGE: begin
        we    = 1'b1;
        waddr = keep;
        wdata = {1'b1, merged_size};
      end
      ST_LINK: begin
        we    = 1'b1;
        waddr = drop;
        wdata = {1'b0, SIZE_W'(keep)};
      end
      default: begin
      end
    endcase
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= ST_CLEAR;
      clr_cnt         <= '0;
      merge_count     <= '0;
      elements_in_use <= dsu_pkg::ELEMENTS_RESET;
    end else if (cfg_we) begin
      elements_in_use <= pwdata[dsu_pkg::COUNT_W-1:0];
      state           <= ST_CLEAR;
      clr_cnt         <= '0;
      merge_count     <= '0;
    end else begin
      case (state)
        ST_CLEAR: begin
          if (clr_cnt == LAST_IDX) begin
            state <= ST_IDLE;
          end else begin
            clr_cnt <= clr_cnt + 1'b1;
          end
        end
        ST_IDLE: begin
          if (accept) begin
            op      <= req.operation;
            err     <= range_bad;
            flag    <= 1'b0;
            phase_b <= 1'b0;
            x       <= IDX_W'(req.first_index);
            second  <= IDX_W'(req.second_index);
            state   <= range_bad ? ST_RESULT : ST_ISSUE;
          end
        end
        ST_ISSUE: begin
          cur   <= x;
          state <= ST_WALK;
        end
        ST_WALK: begin
          if (rd_root) begin
            root      <= cur;
            root_size <= rd_val;
            cur       <= x;
            state     <= ST_COMPRESS;
          end else begin
            cur <= parent;
          end
        end
        ST_COMPRESS: begin
          if (!comp_done) begin
            cur <= parent;
          end else if (!phase_b) begin
            ra <= root;
            sa <= root_size;
            if ((op == dsu_pkg::OP_UNITE) || (op == dsu_pkg::OP_SAME)) begin
              x       <= second;
              phase_b <= 1'b1;
              state   <= ST_ISSUE;
            end else begin
              state <= ST_RESULT;
            end
          end else if (op == dsu_pkg::OP_SAME) begin
            flag  <= (root == ra);
            state <= ST_RESULT;
          end else if (root != ra) begin
            flag  <= 1'b1;
            state <= ST_MERGE;
          end else begin
            state <= ST_RESULT;
          end
        end
        ST_MERGE: begin
          state <= ST_LINK;
        end
        ST_LINK: begin
          ra          <= keep;
          sa          <= merged_size;
          merge_count <= merge_count + 1'b1;
          state       <= ST_RESULT;
        end
        ST_RESULT: begin
          if (!rsp_busy) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_CLEAR;
          clr_cnt <= '0;
        end
      endcase
    end
  end

  // response register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if ((state == ST_RESULT) && !rsp_busy) begin
      rsp_valid <= 1'b1;
    end else if (rsp_valid && !rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  // response payload
  always_ff @(posedge clk) begin
    if ((state == ST_RESULT) && !rsp_busy) begin
      rsp.status      <= err ? dsu_pkg::STATUS_RANGE : dsu_pkg::STATUS_OK;
      rsp.answer_flag <= err ? 1'b0 : flag;
      rsp.root_index  <= err ? '0 : dsu_pkg::INDEX_W'(ra);
      rsp.group_size  <= err ? '0 : dsu_pkg::COUNT_W'(sa);
      rsp.num_groups  <= groups;
    end
  end

  // checks
  `include "disjoint_set_union_engine_assert.svh"

  `DSUE_ASSERT(a_clear_stalls, clk, rst, (state == ST_CLEAR) |-> req_stall, "request taken during clear")
  `DSUE_ASSERT(a_clear_ends, clk, rst, ((state == ST_CLEAR) && (clr_cnt == LAST_IDX) && !cfg_we) |=> (state == ST_IDLE), "clear pass did not end")
  `DSUE_ASSERT_NEVER(a_self_link, clk, rst, (state == ST_LINK) && (keep == drop), "root linked to itself")
  `DSUE_ASSERT(a_merge_bound, clk, rst, (state == ST_MERGE) |-> (32'(merged_size) <= 32'(n_active)), "merged size exceeds elements")
  `DSUE_ASSERT(a_accept_next, clk, rst, (accept && !cfg_we) |=> ((state == ST_ISSUE) || (state == ST_RESULT)), "accepted request not started")

endmodule

FILE: verif/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the disjoint-set union engine: a queue-fed driver
// offers request transactions, a monitor predicts each response from its own
// union-find table and compares every response field, while the element
// count register is rewritten between traffic phases.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;

  // register addresses: element count at index 0, index 1 is not mapped
  localparam logic [dsu_pkg::CFG_ADDR_W-1:0] ELEMENTS_ADDR =
    dsu_pkg::CFG_ADDR_W'(4 * dsu_pkg::REG_ELEMENTS);
  localparam logic [dsu_pkg::CFG_ADDR_W-1:0] UNMAPPED_ADDR = dsu_pkg::CFG_ADDR_W'(4);

  // traffic shaping
  localparam int MODE1_END     = 620;
  localparam int MODE2_END     = 1240;
  localparam int HOLD_AT_RSP   = 1300;
  localparam int HOLD_CYCLES   = 200;
  localparam int SETTLE_CYCLES = 20;

  // one link table entry: parent index, or group size for a root
  typedef struct packed {
    logic                        is_root;
    logic [dsu_pkg::COUNT_W-1:0] value;
  } link_entry_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  // dut ports
  dsu_pkg::req_t     req       = '0;
  logic              req_valid = 1'b0;
  logic              req_stall;
  dsu_pkg::rsp_t     rsp;
  logic              rsp_valid;
  logic              rsp_stall = 1'b0;
  logic              psel      = 1'b0;
  logic              penable   = 1'b0;
  logic              pwrite    = 1'b0;
  logic [dsu_pkg::CFG_ADDR_W-1:0] paddr = '0;
  logic [31:0]       pwdata    = '0;
  logic [31:0]       prdata;
  logic              pready;

  // predicted engine state
  link_entry_t                 links [dsu_pkg::MAX_ELEMENTS];
  logic [dsu_pkg::INDEX_W-1:0] merges;
  logic [dsu_pkg::COUNT_W-1:0] elements_reg;

  // bench bookkeeping
  dsu_pkg::req_t     pending_reqs [$];
  dsu_pkg::rsp_t     expected_results [$];
  logic              req_fire = 1'b0;
  int                req_sent = 0;
  int                rsp_done = 0;
  int                mismatches = 0;
  int                hold_left = 0;
  bit                hold_done = 1'b0;
  int                hot_base = 0;
  dsu_pkg::rsp_t     got_rsp;
  dsu_pkg::rsp_t     want_rsp;

  disjoint_set_union_engine i_dut (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .rsp       (rsp),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  // clock
  initial begin
    forever #10 clk = ~clk;
  end

  // run limit
  initial begin
    #20_000_000;
    $display("end of test: mismatches");
    $finish;
  end

  // ---------------------------------------------------------------- predictor

  // every element its own root of size one, no merges
  function automatic void rebuild_table();
    for (int i = 0; i < dsu_pkg::MAX_ELEMENTS; i++) begin
      links[i].is_root = 1'b1;
      links[i].value   = dsu_pkg::COUNT_W'(1);
    end
    merges = '0;
  endfunction

  // register value saturates at the table depth
  function automatic int active_elements();
    return (elements_reg > dsu_pkg::MAX_ELEMENTS) ? dsu_pkg::MAX_ELEMENTS
                                                  : int'(elements_reg);
  endfunction

  // walk to the root, then point each node on the path straight at it
  function automatic logic [dsu_pkg::INDEX_W-1:0] root_with_compress(
    input logic [dsu_pkg::INDEX_W-1:0] x
  );
    logic [dsu_pkg::INDEX_W-1:0] r;
    logic [dsu_pkg::INDEX_W-1:0] node;
    logic [dsu_pkg::INDEX_W-1:0] nxt;
    r = x;
    while (!links[r].is_root) r = links[r].value[dsu_pkg::INDEX_W-1:0];
    node = x;
    while (node != r && !links[node].is_root) begin
      nxt = links[node].value[dsu_pkg::INDEX_W-1:0];
      links[node].value = {1'b0, r};
      node = nxt;
    end
    return r;
  endfunction

  // apply one request to the predicted table and form its response
  function automatic dsu_pkg::rsp_t predict_result(input dsu_pkg::req_t r);
    int                          n;
    logic                        uses_second;
    logic [dsu_pkg::INDEX_W-1:0] ra;
    logic [dsu_pkg::INDEX_W-1:0] rb;
    logic [dsu_pkg::INDEX_W-1:0] keep;
    logic [dsu_pkg::INDEX_W-1:0] drop;
    logic [dsu_pkg::COUNT_W-1:0] sa;
    logic [dsu_pkg::COUNT_W-1:0] sb;
    dsu_pkg::rsp_t               res;
    n = active_elements();
    uses_second = (r.operation == dsu_pkg::OP_UNITE) || (r.operation == dsu_pkg::OP_SAME);
    res = '0;
    if (int'(r.first_index) >= n || (uses_second && int'(r.second_index) >= n)) begin
      // range error leaves the table alone
      res.status = dsu_pkg::STATUS_RANGE;
    end else begin
      res.status = dsu_pkg::STATUS_OK;
      ra = root_with_compress(r.first_index);
      if (uses_second) begin
        rb = root_with_compress(r.second_index);
        if (r.operation == dsu_pkg::OP_UNITE) begin
          if (ra != rb) begin
            // union by size, first root wins a tie
            sa = links[ra].value;
            sb = links[rb].value;
            keep = ra;
            drop = rb;
            if (sa < sb) begin
              keep = rb;
              drop = ra;
            end
            links[keep].value   = sa + sb;
            links[drop].is_root = 1'b0;
            links[drop].value   = {1'b0, keep};
            merges = merges + 1'b1;
            res.answer_flag = 1'b1;
            ra = keep;
          end
        end else begin
          res.answer_flag = (ra == rb);
        end
      end
      res.root_index = ra;
      res.group_size = links[ra].value;
    end
    res.num_groups = (n > int'(merges)) ? dsu_pkg::COUNT_W'(n - int'(merges)) : '0;
    return res;
  endfunction

  // ------------------------------------------------------------ traffic shape

  function automatic int send_idle_pct();
    if (req_sent < MODE1_END) return 28;
    if (req_sent < MODE2_END) return 87;
    return 0;
  endfunction

  function automatic int recv_idle_pct();
    if (req_sent < MODE1_END) return 87;
    if (req_sent < MODE2_END) return 28;
    return 0;
  endfunction

  // ------------------------------------------------------------- driver side

  // request driver: a new transaction only once the last one was taken
  always @(negedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else if (!req_valid || req_fire) begin
      if (pending_reqs.size() != 0 && $urandom_range(99) >= send_idle_pct()) begin
        req       <= pending_reqs.pop_front();
        req_valid <= 1'b1;
      end else begin
        req_valid <= 1'b0;
      end
    end
  end

  // response stall, with one long hold-off to back the engine up
  always @(negedge clk) begin
    if (rst) begin
      rsp_stall <= 1'b0;
    end else begin
      if (!hold_done && rsp_done >= HOLD_AT_RSP) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left = hold_left - 1;
        rsp_stall <= 1'b1;
      end else begin
        rsp_stall <= ($urandom_range(99) < recv_idle_pct());
      end
    end
  end

  // ------------------------------------------------------------------ monitor

  task automatic compare_result(input dsu_pkg::rsp_t want, input dsu_pkg::rsp_t got);
    if (got.status !== want.status) begin
      $error("status: expected %0d, got %0d", want.status, got.status);
      mismatches++;
    end
    if (got.answer_flag !== want.answer_flag) begin
      $error("answer_flag: expected %0d, got %0d", want.answer_flag, got.answer_flag);
      mismatches++;
    end
    if (got.root_index !== want.root_index) begin
      $error("root_index: expected %0d, got %0d", want.root_index, got.root_index);
      mismatches++;
    end
    if (got.group_size !== want.group_size) begin
      $error("group_size: expected %0d, got %0d", want.group_size, got.group_size);
      mismatches++;
    end
    if (got.num_groups !== want.num_groups) begin
      $error("num_groups: expected %0d, got %0d", want.num_groups, got.num_groups);
      mismatches++;
    end
  endtask

  // responses are checked before the request of the same edge is predicted
  always @(posedge clk) begin
    if (rst) begin
      req_fire = 1'b0;
    end else begin
      if (rsp_valid && !rsp_stall) begin
        got_rsp = rsp;
        if (expected_results.size() == 0) begin
          $error("response transaction with no request outstanding");
          mismatches++;
        end else begin
          want_rsp = expected_results.pop_front();
          compare_result(want_rsp, got_rsp);
        end
        rsp_done++;
      end
      req_fire = req_valid && !req_stall;
      if (req_fire) begin
        expected_results = {expected_results, predict_result(req)};
        req_sent++;
      end
    end
  end

  // ---------------------------------------------------------------- stimulus

  task automatic add_item(input logic [dsu_pkg::OP_W-1:0] op, input int a, input int b);
    dsu_pkg::req_t r;
    r.operation    = op;
    r.first_index  = dsu_pkg::INDEX_W'(a);
    r.second_index = dsu_pkg::INDEX_W'(b);
    pending_reqs = {pending_reqs, r};
  endtask

  // mostly a hot window of 32 elements so groups grow deep
  function automatic int pick_index();
    int n;
    int roll;
    n = active_elements();
    roll = $urandom_range(99);
    if (n == 0) return $urandom_range(dsu_pkg::MAX_ELEMENTS - 1);
    if (n < dsu_pkg::MAX_ELEMENTS && roll < 8) return $urandom_range(dsu_pkg::MAX_ELEMENTS - 1, n);
    if (n > 32 && roll < 60) return hot_base + $urandom_range(31);
    return $urandom_range(n - 1);
  endfunction

  task automatic add_random(input int count);
    int                          n;
    int                          roll;
    logic [dsu_pkg::OP_W-1:0]    op;
    int                          a;
    int                          b;
    n = active_elements();
    hot_base = (n > 32) ? $urandom_range(n - 32) : 0;
    for (int i = 0; i < count; i++) begin
      roll = $urandom_range(99);
      if (roll < 40) op = dsu_pkg::OP_UNITE;
      else if (roll < 60) op = dsu_pkg::OP_SAME;
      else if (roll < 80) op = dsu_pkg::OP_FIND;
      else op = dsu_pkg::OP_SIZE;
      a = pick_index();
      // second index is ignored by find and size, so any value goes
      if (op == dsu_pkg::OP_UNITE || op == dsu_pkg::OP_SAME) b = pick_index();
      else b = $urandom_range(dsu_pkg::MAX_ELEMENTS - 1);
      add_item(op, a, b);
    end
  endtask

  // wait until every request is taken and answered
  task automatic drain();
    do @(posedge clk);
    while (pending_reqs.size() != 0 || req_valid || expected_results.size() != 0);
    repeat (8) @(posedge clk);
  endtask

  // apb write: setup cycle then access cycle
  task automatic cfg_write(input logic [dsu_pkg::CFG_ADDR_W-1:0] addr,
                           input logic [31:0] data);
    @(negedge clk);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= addr;
    pwdata  <= data;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    // a write of the element count rebuilds the whole table
    if (addr[dsu_pkg::CFG_ADDR_W-1:2] == dsu_pkg::REG_ELEMENTS) begin
      elements_reg = data[dsu_pkg::COUNT_W-1:0];
      rebuild_table();
    end
  endtask

  initial begin
    rebuild_table();
    elements_reg = dsu_pkg::ELEMENTS_RESET;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // full table after reset: ties, merges, repeats, extremes
    add_item(dsu_pkg::OP_UNITE, 0, 1);
    add_item(dsu_pkg::OP_UNITE, 3, 2);
    add_item(dsu_pkg::OP_UNITE, 1, 3);
    add_item(dsu_pkg::OP_UNITE, 1023, 0);
    add_item(dsu_pkg::OP_UNITE, 0, 1023);
    add_item(dsu_pkg::OP_SAME, 1023, 2);
    add_item(dsu_pkg::OP_SAME, 512, 1023);
    add_item(dsu_pkg::OP_FIND, 2, 1023);
    add_item(dsu_pkg::OP_FIND, 1023, 0);
    add_item(dsu_pkg::OP_SIZE, 3, 0);
    add_item(dsu_pkg::OP_SIZE, 511, 1023);
    add_random(350);
    drain();

    // small table, out-of-range indices
    cfg_write(ELEMENTS_ADDR, 32'd16);
    add_item(dsu_pkg::OP_UNITE, 16, 0);
    add_item(dsu_pkg::OP_UNITE, 0, 16);
    add_item(dsu_pkg::OP_SAME, 15, 1023);
    add_item(dsu_pkg::OP_FIND, 16, 3);
    add_item(dsu_pkg::OP_SIZE, 1023, 0);
    add_item(dsu_pkg::OP_FIND, 15, 1023);
    add_item(dsu_pkg::OP_SIZE, 0, 600);
    add_random(250);
    drain();

    // unmapped register must leave the table untouched
    cfg_write(UNMAPPED_ADDR, 32'd3);
    add_random(100);
    drain();

    // no valid index at all
    cfg_write(ELEMENTS_ADDR, 32'd0);
    add_random(40);
    drain();

    // single element
    cfg_write(ELEMENTS_ADDR, 32'd1);
    add_item(dsu_pkg::OP_UNITE, 0, 0);
    add_random(40);
    drain();

    // count above the table saturates
    cfg_write(ELEMENTS_ADDR, 32'd2047);
    add_item(dsu_pkg::OP_UNITE, 1023, 1022);
    add_item(dsu_pkg::OP_SIZE, 1023, 0);
    add_item(dsu_pkg::OP_FIND, 1022, 0);
    add_random(300);
    drain();

    cfg_write(ELEMENTS_ADDR, 32'd2);
    add_random(60);
    drain();

    // bits above the register width are dropped
    cfg_write(ELEMENTS_ADDR, 32'hFFFF_F828);
    add_random(300);
    drain();

    cfg_write(ELEMENTS_ADDR, 32'd1024);
    add_random(400);
    drain();

    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
